[rtl/pef_pkg.sv]
package pef_pkg;

  // fixed field widths
  localparam int COORD_W    = 6;
  localparam int CHAN_W     = 8;
  localparam int MODE_W     = 2;
  localparam int SIZE_W     = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam int PIXEL_W    = 4 * CHAN_W;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_EFFECT_MODE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  // effect codes
  localparam logic [MODE_W-1:0] EFFECT_PASS   = 2'd0;
  localparam logic [MODE_W-1:0] EFFECT_GRAY   = 2'd1;
  localparam logic [MODE_W-1:0] EFFECT_INVERT = 2'd2;
  localparam logic [MODE_W-1:0] EFFECT_BLUR   = 2'd3;

  // item modes
  localparam logic ITEM_LOAD    = 1'b0;
  localparam logic ITEM_COMPUTE = 1'b1;

  // grayscale weights and divide by reciprocal multiply
  localparam int GRAY_R      = 30;
  localparam int GRAY_G      = 59;
  localparam int GRAY_B      = 11;
  localparam int GRAY_DIV    = 100;
  localparam int GRAY_SUM_W  = 15;
  localparam int GRAY_SHIFT  = GRAY_SUM_W + 7;
  localparam int GRAY_RECIP  = ((1 << GRAY_SHIFT) + GRAY_DIV - 1) / GRAY_DIV;
  localparam int GRAY_RCP_W  = 16;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // controller to datapath commands
  typedef struct packed {
    logic accept_load;
    logic accept_compute;
    logic use_tap;
    logic tap_step;
    logic acc_add;
    logic latch;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic blur;
    logic last_tap;
  } dp_status_t;

endpackage

[rtl/pixel_effect_filter_core.sv]
// load transaction: written at the accept edge if inside the frame, busy stays low, one load per cycle
// compute transaction: done follows the controller states READ, LATCH and FIN for
//   pass-through, grayscale and invert, and BLUR, DRAIN and FIN for blur, where BLUR
//   steps through the window as the single-port pixel store gives one window pixel a cycle
// the next transaction is accepted in the cycle done is high; done cannot be stalled
// rst (synchronous) idles the controller and resets the configuration and tap registers; the store is not cleared
module pixel_effect_filter_core #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_HEIGHT  = 64,
  parameter int BLUR_RADIUS = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode,
  input  logic [pef_pkg::COORD_W-1:0]    column,
  input  logic [pef_pkg::COORD_W-1:0]    row,
  input  logic [pef_pkg::CHAN_W-1:0]     in_alpha,
  input  logic [pef_pkg::CHAN_W-1:0]     in_red,
  input  logic [pef_pkg::CHAN_W-1:0]     in_green,
  input  logic [pef_pkg::CHAN_W-1:0]     in_blue,
  output logic                           done,
  output logic [pef_pkg::CHAN_W-1:0]     out_alpha,
  output logic [pef_pkg::CHAN_W-1:0]     out_red,
  output logic [pef_pkg::CHAN_W-1:0]     out_green,
  output logic [pef_pkg::CHAN_W-1:0]     out_blue,
  input  logic                           cfg_we,
  input  logic [pef_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pef_pkg::CFG_DATA_W-1:0] cfg_data
);

  import pef_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing
  pef_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  // store, accumulators and effect arithmetic
  pef_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .BLUR_RADIUS (BLUR_RADIUS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .column    (column),
    .row       (row),
    .in_alpha  (in_alpha),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_alpha (out_alpha),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  // a result only ends a busy stretch
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a compute in flight");

  // a compute transaction always occupies the block
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == ITEM_COMPUTE) |=> busy)
    else $error("compute accepted but block not busy");

  // a load gives no result and leaves the block free
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == ITEM_LOAD) |=> (!busy && !done))
    else $error("load transaction produced activity");

  // one strobe per result
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

[rtl/pef_ram.sv]
module pef_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/pef_ctrl.sv]
module pef_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                mode,
  input  pef_pkg::dp_status_t status,
  output logic                busy,
  output logic                done,
  output pef_pkg::ctrl_cmd_t  cmd
);

  import pef_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_LATCH = 3'd2;
  localparam logic [2:0] ST_BLUR  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       pend;

  assign busy = (state != ST_IDLE);

  // command decode
  always_comb begin
    cmd.accept_load    = start && !busy && (mode == ITEM_LOAD);
    cmd.accept_compute = start && !busy && (mode == ITEM_COMPUTE);
    cmd.use_tap        = (state == ST_BLUR);
    cmd.tap_step       = (state == ST_BLUR);
    cmd.acc_add        = pend;
    cmd.latch          = (state == ST_LATCH);
    cmd.out_load       = (state == ST_FIN);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept_compute) begin
          state_next = status.blur ? ST_BLUR : ST_READ;
        end
      end
      ST_READ:  state_next = ST_LATCH;
      ST_LATCH: state_next = ST_FIN;
      ST_BLUR: begin
        if (status.last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FIN;
      ST_FIN:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state, read-pending flag and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_BLUR);
      done  <= (state == ST_FIN);
    end
  end

endmodule

[rtl/pef_datapath.sv]
module pef_datapath #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_HEIGHT  = 64,
  parameter int BLUR_RADIUS = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pef_pkg::ctrl_cmd_t                  cmd,
  output pef_pkg::dp_status_t                 status,
  input  logic                                cfg_we,
  input  logic [pef_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pef_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [pef_pkg::COORD_W-1:0]         column,
  input  logic [pef_pkg::COORD_W-1:0]         row,
  input  logic [pef_pkg::CHAN_W-1:0]          in_alpha,
  input  logic [pef_pkg::CHAN_W-1:0]          in_red,
  input  logic [pef_pkg::CHAN_W-1:0]          in_green,
  input  logic [pef_pkg::CHAN_W-1:0]          in_blue,
  output logic [pef_pkg::CHAN_W-1:0]          out_alpha,
  output logic [pef_pkg::CHAN_W-1:0]          out_red,
  output logic [pef_pkg::CHAN_W-1:0]          out_green,
  output logic [pef_pkg::CHAN_W-1:0]          out_blue
);

  import pef_pkg::*;

  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int AW        = XW + YW;
  localparam int BOX_SIDE  = 2 * BLUR_RADIUS + 1;
  localparam int BOX_COUNT = BOX_SIDE * BOX_SIDE;
  localparam int TW        = $clog2(BOX_SIDE);
  localparam int SUM_W     = $clog2(BOX_COUNT * 255 + 1);
  localparam int ACC_W     = (SUM_W > GRAY_SUM_W) ? SUM_W : GRAY_SUM_W;
  localparam int BOX_SHIFT = ACC_W + 8;
  localparam longint BOX_RECIP =
    ((longint'(1) << BOX_SHIFT) + BOX_COUNT - 1) / BOX_COUNT;
  localparam int BP_W      = ACC_W + BOX_SHIFT + 1;
  localparam int GP_W      = GRAY_SUM_W + GRAY_RCP_W;

  // configuration registers
  logic [MODE_W-1:0] effect_mode;
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode  <= EFFECT_PASS;
      frame_width  <= SIZE_W'(64);
      frame_height <= SIZE_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_EFFECT_MODE:  effect_mode  <= cfg_data[MODE_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // last column and row of the effective frame
  logic [XW-1:0] last_x;
  logic [YW-1:0] last_y;

  always_comb begin
    if (frame_width == '0) begin
      last_x = '0;
    end else if (int'(frame_width) > MAX_WIDTH) begin
      last_x = XW'(MAX_WIDTH - 1);
    end else begin
      last_x = XW'(frame_width - SIZE_W'(1));
    end
    if (frame_height == '0) begin
      last_y = '0;
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      last_y = YW'(MAX_HEIGHT - 1);
    end else begin
      last_y = YW'(frame_height - SIZE_W'(1));
    end
  end

  logic in_frame;
  assign in_frame = (int'(column) <= int'(last_x)) && (int'(row) <= int'(last_y));

  // clamped center of a compute transaction
  logic [XW-1:0] xc;
  logic [YW-1:0] yc;

  always_ff @(posedge clk) begin
    if (cmd.accept_compute) begin
      xc <= (int'(column) > int'(last_x)) ? last_x : XW'(column);
      yc <= (int'(row) > int'(last_y)) ? last_y : YW'(row);
    end
  end

  // blur window tap counters
  logic [TW-1:0] tap_x;
  logic [TW-1:0] tap_y;
  logic          tap_x_end;

  assign tap_x_end       = (tap_x == TW'(BOX_SIDE - 1));
  assign status.last_tap = tap_x_end && (tap_y == TW'(BOX_SIDE - 1));
  assign status.blur     = (effect_mode == EFFECT_BLUR);

  always_ff @(posedge clk) begin
    if (rst || cmd.accept_compute) begin
      tap_x <= '0;
      tap_y <= '0;
    end else if (cmd.tap_step) begin
      if (tap_x_end) begin
        tap_x <= '0;
        tap_y <= tap_y + TW'(1);
      end else begin
        tap_x <= tap_x + TW'(1);
      end
    end
  end

  // tap coordinates clamped to the frame edges
  logic [XW-1:0] tx;
  logic [YW-1:0] ty;

  always_comb begin
    int sx;
    int sy;
    sx = int'(xc) + int'(tap_x) - BLUR_RADIUS;
    sy = int'(yc) + int'(tap_y) - BLUR_RADIUS;
    if (sx < 0) begin
      tx = '0;
    end else if (sx > int'(last_x)) begin
      tx = last_x;
    end else begin
      tx = XW'(sx);
    end
    if (sy < 0) begin
      ty = '0;
    end else if (sy > int'(last_y)) begin
      ty = last_y;
    end else begin
      ty = YW'(sy);
    end
  end

  // pixel store port
  logic [AW-1:0]      ram_addr;
  logic               ram_we;
  logic [PIXEL_W-1:0] ram_wdata;
  logic [PIXEL_W-1:0] ram_rdata;

  always_comb begin
    priority if (cmd.accept_load) begin
      ram_addr = {YW'(row), XW'(column)};
    end else if (cmd.use_tap) begin
      ram_addr = {ty, tx};
    end else begin
      ram_addr = {yc, xc};
    end
  end

  assign ram_we    = cmd.accept_load && in_frame;
  assign ram_wdata = {in_alpha, in_red, in_green, in_blue};

  pef_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (1 << AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  logic [CHAN_W-1:0] rd_a, rd_r, rd_g, rd_b;
  assign {rd_a, rd_r, rd_g, rd_b} = ram_rdata;

  // grayscale weighted sum
  logic [GRAY_SUM_W-1:0] gray_sum;
  assign gray_sum = GRAY_SUM_W'(GRAY_R * int'(rd_r) + GRAY_G * int'(rd_g)
                                + GRAY_B * int'(rd_b));

  // channel accumulators
  logic [ACC_W-1:0] acc_a, acc_r, acc_g, acc_b;

  always_ff @(posedge clk) begin
    if (cmd.accept_compute) begin
      acc_a <= '0;
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else if (cmd.acc_add) begin
      acc_a <= acc_a + ACC_W'(rd_a);
      acc_r <= acc_r + ACC_W'(rd_r);
      acc_g <= acc_g + ACC_W'(rd_g);
      acc_b <= acc_b + ACC_W'(rd_b);
    end else if (cmd.latch) begin
      acc_a <= ACC_W'(rd_a);
      acc_r <= (effect_mode == EFFECT_GRAY) ? ACC_W'(gray_sum) : ACC_W'(rd_r);
      acc_g <= ACC_W'(rd_g);
      acc_b <= ACC_W'(rd_b);
    end
  end

  // box mean by reciprocal multiply, one lane per channel
  logic [BP_W-1:0] bp_a, bp_r, bp_g, bp_b;
  assign bp_a = BP_W'(acc_a) * BP_W'(BOX_RECIP);
  assign bp_r = BP_W'(acc_r) * BP_W'(BOX_RECIP);
  assign bp_g = BP_W'(acc_g) * BP_W'(BOX_RECIP);
  assign bp_b = BP_W'(acc_b) * BP_W'(BOX_RECIP);

  // gray divide by reciprocal multiply
  logic [GP_W-1:0]   gp;
  logic [CHAN_W-1:0] gray;
  assign gp   = GP_W'(acc_r[GRAY_SUM_W-1:0]) * GP_W'(GRAY_RECIP);
  assign gray = gp[GRAY_SHIFT +: CHAN_W];

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (effect_mode)
        EFFECT_PASS: begin
          out_alpha <= acc_a[CHAN_W-1:0];
          out_red   <= acc_r[CHAN_W-1:0];
          out_green <= acc_g[CHAN_W-1:0];
          out_blue  <= acc_b[CHAN_W-1:0];
        end
        EFFECT_GRAY: begin
          out_alpha <= acc_a[CHAN_W-1:0];
          out_red   <= gray;
          out_green <= gray;
          out_blue  <= gray;
        end
        EFFECT_INVERT: begin
          out_alpha <= acc_a[CHAN_W-1:0];
          out_red   <= CHAN_MAX - acc_r[CHAN_W-1:0];
          out_green <= CHAN_MAX - acc_g[CHAN_W-1:0];
          out_blue  <= CHAN_MAX - acc_b[CHAN_W-1:0];
        end
        EFFECT_BLUR: begin
          out_alpha <= bp_a[BOX_SHIFT +: CHAN_W];
          out_red   <= bp_r[BOX_SHIFT +: CHAN_W];
          out_green <= bp_g[BOX_SHIFT +: CHAN_W];
          out_blue  <= bp_b[BOX_SHIFT +: CHAN_W];
        end
        default: ;
      endcase
    end
  end

endmodule

[verif/tb_pixel_effect_filter_core.sv]
`timescale 1ns / 1ps

module tb_pixel_effect_filter_core;
  import pef_pkg::*;

  localparam int MAX_W         = 64;
  localparam int MAX_H         = 64;
  localparam int RADIUS        = 3;
  localparam int BOX_N         = (2 * RADIUS + 1) * (2 * RADIUS + 1);
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 100;
  localparam int FILL_SIDE     = 16;
  localparam int CORNER        = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } argb_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  mode;
  logic [COORD_W-1:0]    column;
  logic [COORD_W-1:0]    row;
  logic [CHAN_W-1:0]     in_alpha;
  logic [CHAN_W-1:0]     in_red;
  logic [CHAN_W-1:0]     in_green;
  logic [CHAN_W-1:0]     in_blue;
  logic                  done;
  logic [CHAN_W-1:0]     out_alpha;
  logic [CHAN_W-1:0]     out_red;
  logic [CHAN_W-1:0]     out_green;
  logic [CHAN_W-1:0]     out_blue;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow copy of the frame and the registers
  argb_t             frame_copy [MAX_W * MAX_H];
  logic [MODE_W-1:0] cur_effect;
  logic [SIZE_W-1:0] cur_width;
  logic [SIZE_W-1:0] cur_height;

  argb_t pending_pixels [$];
  int    fail_count;
  int    burst_left;
  bit    steady;

  pixel_effect_filter_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .BLUR_RADIUS(RADIUS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .column   (column),
    .row      (row),
    .in_alpha (in_alpha),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .done     (done),
    .out_alpha(out_alpha),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // register value to usable frame dimension, 0 acts as 1
  function automatic int eff_dim(logic [SIZE_W-1:0] v, int limit);
    if (v < 1) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic int clamp_to(int v, int last);
    if (v < 0) return 0;
    if (v > last) return last;
    return v;
  endfunction

  // top-left square plus the two right-hand corners
  function automatic bit in_fill(int x, int y);
    return (x < FILL_SIDE && y < FILL_SIDE) ||
           (x >= MAX_W - CORNER && (y < CORNER || y >= MAX_H - CORNER));
  endfunction

  // truncating mean of the window around (x, y), edges replicated
  function automatic argb_t box_average(int x, int y, int lastx, int lasty);
    int    sa, sr, sg, sb;
    argb_t p;
    argb_t res;
    sa = 0;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
      for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
        p = frame_copy[clamp_to(y + dy, lasty) * MAX_W + clamp_to(x + dx, lastx)];
        sa += p.a;
        sr += p.r;
        sg += p.g;
        sb += p.b;
      end
    end
    res.a = CHAN_W'(sa / BOX_N);
    res.r = CHAN_W'(sr / BOX_N);
    res.g = CHAN_W'(sg / BOX_N);
    res.b = CHAN_W'(sb / BOX_N);
    return res;
  endfunction

  // result pixel of a compute transaction under the current settings
  function automatic argb_t predict_effect(int x, int y);
    int    w, h, cx, cy, gray;
    argb_t src;
    argb_t res;
    w   = eff_dim(cur_width, MAX_W);
    h   = eff_dim(cur_height, MAX_H);
    cx  = clamp_to(x, w - 1);
    cy  = clamp_to(y, h - 1);
    src = frame_copy[cy * MAX_W + cx];
    case (cur_effect)
      EFFECT_GRAY: begin
        gray  = (GRAY_R * src.r + GRAY_G * src.g + GRAY_B * src.b) / GRAY_DIV;
        res.a = src.a;
        res.r = CHAN_W'(gray);
        res.g = CHAN_W'(gray);
        res.b = CHAN_W'(gray);
      end
      EFFECT_INVERT: begin
        res.a = src.a;
        res.r = CHAN_MAX - src.r;
        res.g = CHAN_MAX - src.g;
        res.b = CHAN_MAX - src.b;
      end
      EFFECT_BLUR: res = box_average(cx, cy, w - 1, h - 1);
      default: res = src;
    endcase
    return res;
  endfunction

  // update the shadow state for one accepted transaction
  function automatic void apply_item(logic m, int x, int y, argb_t pix);
    if (m == ITEM_LOAD) begin
      if (x < eff_dim(cur_width, MAX_W) && y < eff_dim(cur_height, MAX_H))
        frame_copy[y * MAX_W + x] = pix;
    end else begin
      pending_pixels.push_back(predict_effect(x, y));
    end
  endfunction

  function automatic void check_chan(string name, logic [CHAN_W-1:0] want,
                                     logic [CHAN_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    argb_t got;
    argb_t want;
    if (!rst && done) begin
      got = {out_alpha, out_red, out_green, out_blue};
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %08h", $time, got);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_chan("alpha", want.a, got.a);
        check_chan("red", want.r, got.r);
        check_chan("green", want.g, got.g);
        check_chan("blue", want.b, got.b);
      end
    end
  end

  // start held low for the given idle length, payload ports carry noise
  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start    = 1'b0;
      mode     = 1'($urandom);
      column   = COORD_W'($urandom);
      row      = COORD_W'($urandom);
      in_alpha = CHAN_W'($urandom);
      in_red   = CHAN_W'($urandom);
      in_green = CHAN_W'($urandom);
      in_blue  = CHAN_W'($urandom);
    end
  endtask

  // one transaction, returns at the accepting edge
  task automatic send_item(logic m, int x, int y, argb_t pix);
    @(negedge clk);
    start    = 1'b1;
    mode     = m;
    column   = COORD_W'(x);
    row      = COORD_W'(y);
    in_alpha = pix.a;
    in_red   = pix.r;
    in_green = pix.g;
    in_blue  = pix.b;
    do @(posedge clk); while (busy);
    apply_item(m, x, y, pix);
    // bursts of random length with short or long gaps between them
    if (!steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        if ($urandom_range(0, 7) == 0)
          idle_for($urandom_range(8, 60));
        else
          idle_for($urandom_range(1, 3));
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  // wait until every expected result is in and the block is quiet
  task automatic drain();
    idle_for(1);
    while (pending_pixels.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = addr;
    cfg_data = data;
    @(posedge clk);
    case (addr)
      REG_EFFECT_MODE:  cur_effect = data[MODE_W-1:0];
      REG_FRAME_WIDTH:  cur_width  = data;
      REG_FRAME_HEIGHT: cur_height = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // upper bits of the effect write are don't-care and get noise
  task automatic set_frame(logic [MODE_W-1:0] eff, logic [SIZE_W-1:0] w,
                           logic [SIZE_W-1:0] h);
    drain();
    write_reg(REG_EFFECT_MODE, {(CFG_DATA_W - MODE_W)'($urandom), eff});
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // every store entry that later transactions read is written first
  task automatic test_fill_frame();
    for (int y = 0; y < MAX_H; y++)
      for (int x = 0; x < MAX_W; x++)
        if (in_fill(x, y))
          send_item(ITEM_LOAD, x, y, argb_t'($urandom));
  endtask

  // corners, channel extremes, every effect, clamping and size limits
  task automatic test_directed();
    set_frame(EFFECT_PASS, 7'd64, 7'd64);
    send_item(ITEM_LOAD, 0, 0, argb_t'(32'hFFFF_FFFF));
    send_item(ITEM_LOAD, 63, 63, argb_t'(32'h0000_0000));
    send_item(ITEM_COMPUTE, 0, 0, '0);
    send_item(ITEM_COMPUTE, 63, 63, '0);
    send_item(ITEM_COMPUTE, 63, 0, '0);
    set_frame(EFFECT_GRAY, 7'd64, 7'd64);
    send_item(ITEM_COMPUTE, 0, 0, '0);
    send_item(ITEM_COMPUTE, 63, 63, '0);
    send_item(ITEM_COMPUTE, 10, 12, '0);
    set_frame(EFFECT_INVERT, 7'd64, 7'd64);
    send_item(ITEM_COMPUTE, 0, 0, '0);
    send_item(ITEM_COMPUTE, 63, 63, '0);
    set_frame(EFFECT_BLUR, 7'd64, 7'd64);
    send_item(ITEM_COMPUTE, 0, 0, '0);
    send_item(ITEM_COMPUTE, 63, 63, '0);
    send_item(ITEM_COMPUTE, 8, 8, '0);
    // small frame: loads beyond it dropped, computes clamped
    set_frame(EFFECT_PASS, 7'd5, 7'd3);
    send_item(ITEM_LOAD, 5, 1, argb_t'(32'h1234_5678));
    send_item(ITEM_LOAD, 4, 2, argb_t'(32'h80FF_007F));
    send_item(ITEM_LOAD, 1, 3, argb_t'(32'hDEAD_BEEF));
    send_item(ITEM_COMPUTE, 63, 63, '0);
    send_item(ITEM_COMPUTE, 5, 1, '0);
    set_frame(EFFECT_BLUR, 7'd5, 7'd3);
    send_item(ITEM_COMPUTE, 2, 1, '0);
    // zero size acts as one pixel
    set_frame(EFFECT_BLUR, 7'd0, 7'd0);
    send_item(ITEM_LOAD, 1, 0, argb_t'(32'h0102_0304));
    send_item(ITEM_LOAD, 0, 0, argb_t'(32'hA0B0_C0D0));
    send_item(ITEM_COMPUTE, 40, 40, '0);
    // oversized register acts as the full frame
    set_frame(EFFECT_PASS, 7'd127, 7'd127);
    send_item(ITEM_COMPUTE, 63, 63, '0);
  endtask

  // frame sizes stay inside the filled square
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return SIZE_W'(FILL_SIDE);
      default: return SIZE_W'($urandom_range(2, FILL_SIDE - 1));
    endcase
  endfunction

  // random loads and computes over several frame settings
  task automatic test_random();
    int w, h, x, y;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        set_frame(EFFECT_BLUR, SIZE_W'(FILL_SIDE), SIZE_W'(FILL_SIDE));
      else if (phase == RANDOM_PHASES - 1)
        set_frame(EFFECT_BLUR, 7'd1, SIZE_W'(FILL_SIDE));
      else
        set_frame(MODE_W'(phase % 4), pick_size(), pick_size());
      // one phase without sender gaps
      steady = (phase == 2);
      w = eff_dim(cur_width, MAX_W);
      h = eff_dim(cur_height, MAX_H);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          x = $urandom_range(0, MAX_W - 1);
          y = $urandom_range(0, MAX_H - 1);
        end else begin
          x = $urandom_range(0, w - 1);
          y = $urandom_range(0, h - 1);
        end
        if ($urandom_range(0, 9) < 4)
          send_item(ITEM_LOAD, x, y, argb_t'($urandom));
        else
          send_item(ITEM_COMPUTE, x, y, argb_t'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // main sequence
  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    mode       = ITEM_LOAD;
    column     = '0;
    row        = '0;
    in_alpha   = '0;
    in_red     = '0;
    in_green   = '0;
    in_blue    = '0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_EFFECT_MODE;
    cfg_data   = '0;
    cur_effect = EFFECT_PASS;
    cur_width  = 7'd64;
    cur_height = 7'd64;
    fail_count = 0;
    burst_left = 4;
    steady     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_fill_frame();
    test_directed();
    test_random();
    drain();

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/pef_pkg.sv
rtl/pef_ram.sv
rtl/pef_ctrl.sv
rtl/pef_datapath.sv
rtl/pixel_effect_filter_core.sv
verif/tb_pixel_effect_filter_core.sv
